### hdl/pls_pkg.sv
// shared types and constants for the positional list store
// command codes, field widths, status codes and the per-cell control struct
// no dependencies
package pls_pkg;

   // default sizing of the list
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // fixed field widths
   localparam int POS_W       = 4;
   localparam int CMD_W       = 3;
   localparam int COUNT_OUT_W = 5;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND      = 3'd0,
      CMD_INSERT      = 3'd1,
      CMD_REMOVE_LAST = 3'd2,
      CMD_REMOVE_AT   = 3'd3,
      CMD_READ        = 3'd4
   } cmd_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

### hdl/pls_if.sv
// valid/ready channel interfaces for the positional list store
// command channel and result channel; uses pls_pkg for field widths
interface pls_req_if #(
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEFAULT
);
   import pls_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [POS_W-1:0]      position;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

interface pls_rsp_if #(
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEFAULT
);
   import pls_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   status;
   logic                   found;
   logic [DATA_WIDTH-1:0]  read_value;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, status, found, read_value, entry_count, input ready);
   modport sink   (input valid, status, found, read_value, entry_count, output ready);
endinterface

### hdl/positional_list_store.sv
// positional_list_store: bounded ordered list of data words
//
// Commands arrive on the req_chan channel (command, position, value) and
// each one gives exactly one result on rsp_chan (status, found, read_value,
// entry_count). Commands are append, insert at position, remove last,
// remove at position and read at position. Errors (empty, full, bad
// position, unused code) report status 1 and leave the list unchanged.
//
// The entries sit in a row of DEPTH cells, one word per cell, packed from
// position 0. An insert or remove shifts every cell at or past the target
// position by one toward its neighbor in the same cycle: a transfer at the
// input is answered by the result register on the next cycle, and one command
// per cycle is sustained while the receiver takes each result.
//
// The result register parts the two sides: a new command is taken while a
// waiting result is being taken in the same cycle. When the receiver
// stalls, the result holds and req_chan.ready stays low until it leaves.
// Reset (synchronous, active high) empties the list and drops any pending
// result; cell contents are not cleared, since only filled cells are read.
// depends on pls_pkg, pls_if and pls_cell
module positional_list_store #(
   parameter int DEPTH      = pls_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   pls_req_if.sink   req_chan,
   pls_rsp_if.source rsp_chan
);
   import pls_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int LW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // list state and result register
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   status_ff, status_in;
   logic                   found_ff, found_in;
   logic [DATA_WIDTH-1:0]  read_ff, read_in;
   logic [COUNT_OUT_W-1:0] count_out_ff;

   logic                   accept;
   cmd_type                cmd;
   logic [LW-1:0]          pos_ext, cnt_ext, eff_pos;
   logic                   has_entry, is_full;
   cell_ctl_type           ctl, cell_ctl;
   logic [AW-1:0]          rd_idx;
   logic [DATA_WIDTH-1:0]  row_word [DEPTH];

   // input transfer when the result register is free or draining
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign cmd       = cmd_type'(req_chan.command);
   assign pos_ext   = LW'(req_chan.position);
   assign cnt_ext   = LW'(count_ff);
   assign has_entry = (count_ff != '0);
   assign is_full   = (count_ff == FULL_COUNT);
   assign rd_idx    = AW'(req_chan.position);

   // command decode: target position, success and read data
   always_comb begin
      ctl       = '0;
      eff_pos   = '0;
      status_in = STATUS_ERR;
      found_in  = 1'b0;
      read_in   = '0;
      unique case (cmd)
         CMD_APPEND: begin
            if (!is_full) begin
               status_in  = STATUS_OK;
               ctl.insert = 1'b1;
               eff_pos    = cnt_ext;
            end
         end
         CMD_INSERT: begin
            if (!is_full && (has_entry || (req_chan.position == '0))) begin
               status_in  = STATUS_OK;
               ctl.insert = 1'b1;
               eff_pos    = (pos_ext >= cnt_ext) ? cnt_ext : pos_ext;
            end
         end
         CMD_REMOVE_LAST: begin
            if (has_entry) begin
               status_in  = STATUS_OK;
               ctl.remove = 1'b1;
               eff_pos    = cnt_ext - LW'(1);
            end
         end
         CMD_REMOVE_AT: begin
            if (has_entry) begin
               status_in  = STATUS_OK;
               ctl.remove = 1'b1;
               eff_pos    = ((pos_ext >= cnt_ext) || (count_ff == CW'(1)))
                            ? (cnt_ext - LW'(1)) : pos_ext;
            end
         end
         CMD_READ: begin
            if (has_entry && (pos_ext < cnt_ext)) begin
               status_in = STATUS_OK;
               found_in  = 1'b1;
               read_in   = row_word[rd_idx];
            end
         end
         default: begin
            status_in = STATUS_ERR;
         end
      endcase
   end

   // shift only on an accepted transfer
   assign cell_ctl = accept ? ctl : '0;

   // next count
   always_comb begin
      priority if (cell_ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cell_ctl.remove) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // result valid tracking
   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // row of cells, each wired to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = req_chan.value;
      end else begin : g_mid_l
         assign left_word = row_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = row_word[i];
      end else begin : g_mid_r
         assign right_word = row_word[i+1];
      end

      pls_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .POS_WIDTH  (LW),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .pos        (eff_pos),
         .value      (req_chan.value),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (row_word[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         read_ff      <= read_in;
         count_out_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.found       = found_ff;
   assign rsp_chan.read_value  = read_ff;
   assign rsp_chan.entry_count = count_out_ff;

`ifndef NO_ASSERTIONS
   // append on a full list fails and leaves the count alone
   a_full_append: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && is_full && (cmd == CMD_APPEND))
      |=> (rsp_valid_ff && (status_ff == STATUS_ERR) && (count_ff == $past(count_ff))))
      else $error("append on full list did not fail cleanly");

   // the count moves only on an input transfer
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> $stable(count_ff))
      else $error("count changed without a transfer");

   // the count moves by at most one entry per command
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> ((count_ff == $past(count_ff))
                           || (count_ff == $past(count_ff) + CW'(1))
                           || (count_ff == $past(count_ff) - CW'(1))))
      else $error("count moved by more than one");

   // a found entry is always a successful read
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (status_ff == STATUS_OK))
      else $error("found set on a failed command");
`endif

endmodule

### hdl/pls_cell.sv
// one storage cell of the list row
// holds one entry and takes a new word, its left or its right neighbor's word
// depends on pls_pkg
module pls_cell #(
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEFAULT,
   parameter int POS_WIDTH  = pls_pkg::POS_W,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  pls_pkg::cell_ctl_type  ctl,
   input  logic [POS_WIDTH-1:0]   pos,
   input  logic [DATA_WIDTH-1:0]  value,
   input  logic [DATA_WIDTH-1:0]  left_word,
   input  logic [DATA_WIDTH-1:0]  right_word,
   output logic [DATA_WIDTH-1:0]  word
);
   import pls_pkg::*;

   localparam logic [POS_WIDTH-1:0] MY_POS = POS_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // open a gap on insert, close it on remove
   always_comb begin
      priority if (ctl.insert && (MY_POS == pos)) begin
         word_in = value;
      end else if (ctl.insert && (MY_POS > pos)) begin
         word_in = left_word;
      end else if (ctl.remove && (MY_POS >= pos)) begin
         word_in = right_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### test/positional_list_store_test.sv
// self-checking testbench for the positional list store: directed corner cases, then
// biased random command traffic with random stalls on both channels
// depends on pls_pkg, pls_if and positional_list_store
module positional_list_store_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pls_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int WORD_W       = DATA_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1350;
   localparam int QUIET_ITEMS  = 150;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int REPORT_LIMIT = 10;

   // command codes the block does not define
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic                   status;
      logic                   found;
      logic [WORD_W-1:0]      read_value;
      logic [COUNT_OUT_W-1:0] entry_count;
   } list_answer_type;

   // shadow copy of the list plus the answers still owed by the block
   class list_shadow_type;
      logic [WORD_W-1:0] words [LIST_DEPTH];
      int unsigned       fill;
      list_answer_type   answers [$];
      int unsigned       mismatches;
      int unsigned       faults;

      function new();
         fill       = 0;
         mismatches = 0;
         faults     = 0;
      endfunction

      // shift entries up from a position and drop the word in
      function bit open_gap(int unsigned at, logic [WORD_W-1:0] word);
         if (fill >= LIST_DEPTH || at > fill) return 1'b0;
         for (int unsigned i = fill; i > at; i--) words[i] = words[i-1];
         words[at] = word;
         fill++;
         return 1'b1;
      endfunction

      // shift entries down over a position
      function bit close_gap(int unsigned at);
         if (fill == 0 || at >= fill) return 1'b0;
         for (int unsigned i = at; i + 1 < fill; i++) words[i] = words[i+1];
         fill--;
         return 1'b1;
      endfunction

      // apply one accepted command and queue the answer it owes
      function void note_command(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                                 logic [WORD_W-1:0] word);
         list_answer_type want;
         bit              ok;
         int unsigned     at;
         want = '0;
         ok   = 1'b0;
         at   = 32'(pos);
         case (code)
            CMD_APPEND: ok = open_gap(fill, word);
            CMD_INSERT: begin
               if (fill == 0 && at != 0) ok = 1'b0;
               else if (at >= fill) ok = open_gap(fill, word);
               else ok = open_gap(at, word);
            end
            CMD_REMOVE_LAST: ok = (fill != 0) ? close_gap(fill - 1) : 1'b0;
            CMD_REMOVE_AT: begin
               if (fill == 0) ok = 1'b0;
               else if (at >= fill || fill == 1) ok = close_gap(fill - 1);
               else ok = close_gap(at);
            end
            CMD_READ: begin
               if (at < fill) begin
                  ok              = 1'b1;
                  want.found      = 1'b1;
                  want.read_value = words[at];
               end
            end
            default: ok = 1'b0;
         endcase
         want.status      = ok ? STATUS_OK : STATUS_ERR;
         want.entry_count = COUNT_OUT_W'(fill);
         answers.push_back(want);
      endfunction

      // compare one result transfer with the oldest owed answer
      function void check_answer(logic status, logic found, logic [WORD_W-1:0] read_value,
                                 logic [COUNT_OUT_W-1:0] entry_count);
         list_answer_type want;
         if (answers.size() == 0) begin
            faults++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: stray result: status %b found %b value %h count %0d",
                        $realtime, status, found, read_value, entry_count);
            return;
         end
         want = answers.pop_front();
         if (status !== want.status || found !== want.found ||
             read_value !== want.read_value || entry_count !== want.entry_count) begin
            faults++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch: expected status %b found %b value %h count %0d",
                        $realtime, want.status, want.found, want.read_value,
                        want.entry_count);
               $display("   got status %b found %b value %h count %0d",
                        status, found, read_value, entry_count);
            end
         end
      endfunction

      function int unsigned pending();
         return answers.size();
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   list_shadow_type book = new();
   int unsigned     send_gap_rate;
   int unsigned     take_stall_rate;
   int unsigned     stall_left;
   int unsigned     cycle_count;

   pls_req_if #(.DATA_WIDTH(WORD_W)) req_chan ();
   pls_rsp_if #(.DATA_WIDTH(WORD_W)) rsp_chan ();

   positional_list_store #(
      .DEPTH(LIST_DEPTH),
      .DATA_WIDTH(WORD_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL positional_list_store");
         $finish;
      end
   end

   // receiver stalls in random bursts
   always @(negedge clock) begin
      if (reset || take_stall_rate == 0) begin
         stall_left = 0;
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 15) < take_stall_rate) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         book.check_answer(rsp_chan.status, rsp_chan.found, rsp_chan.read_value,
                           rsp_chan.entry_count);
   end

   // sender gap with junk on the payload
   task automatic hold_off(int unsigned cycles);
      @(negedge clock);
      req_chan.valid    <= 1'b0;
      req_chan.command  <= CMD_W'($urandom);
      req_chan.position <= POS_W'($urandom);
      req_chan.value    <= $urandom;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // offer one command and wait for its transfer
   task automatic push_command(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] word);
      if (send_gap_rate > 0 && $urandom_range(0, 15) < send_gap_rate)
         hold_off($urandom_range(1, 15));
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.command  <= code;
      req_chan.position <= pos;
      req_chan.value    <= word;
      do @(posedge clock); while (!req_chan.ready);
      book.note_command(code, pos, word);
   endtask

   // corner cases: empty, one entry, front, middle, past the end, full
   task automatic corner_cases();
      push_command(CMD_READ, 4'd0, '0);
      push_command(CMD_REMOVE_LAST, 4'd0, '0);
      push_command(CMD_REMOVE_AT, 4'd5, '0);
      push_command(CMD_INSERT, 4'd3, 32'hDEAD_BEEF);
      push_command(CMD_INSERT, 4'd0, '1);
      push_command(CMD_REMOVE_AT, 4'd9, '0);
      push_command(CMD_APPEND, 4'd0, '0);
      push_command(CMD_INSERT, 4'd0, 32'h8000_0001);
      push_command(CMD_INSERT, 4'd15, 32'h5A5A_A5A5);
      push_command(CMD_INSERT, 4'd1, 32'h0123_4567);
      push_command(CMD_READ, 4'd0, '0);
      push_command(CMD_READ, 4'd3, '0);
      push_command(CMD_READ, 4'd15, '0);
      push_command(CMD_REMOVE_AT, 4'd12, '0);
      push_command(CMD_REMOVE_AT, 4'd1, '0);
      push_command(CMD_REMOVE_AT, 4'd0, '0);
      for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
         push_command(CMD_W'(c), 4'd2, '1);
      while (book.fill < LIST_DEPTH)
         push_command(CMD_APPEND, 4'd0, $urandom);
      push_command(CMD_APPEND, 4'd0, 32'h1111_1111);
      push_command(CMD_INSERT, 4'd3, 32'h2222_2222);
      push_command(CMD_INSERT, 4'd15, 32'h3333_3333);
      push_command(CMD_READ, 4'd15, '0);
      push_command(CMD_REMOVE_AT, 4'd8, '0);
      push_command(CMD_REMOVE_LAST, 4'd0, '0);
   endtask

   // random traffic that swings the list between empty and full
   task automatic random_traffic();
      bit                growing;
      int unsigned       roll;
      logic [CMD_W-1:0]  code;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] word;
      growing = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // idling mix per segment, none at the tail
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
            send_gap_rate   = 0;
            take_stall_rate = 0;
         end else if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: send_gap_rate = 0;
               1: send_gap_rate = 2;
               default: send_gap_rate = 6;
            endcase
            case ($urandom_range(0, 2))
               0: take_stall_rate = 0;
               1: take_stall_rate = 2;
               default: take_stall_rate = 6;
            endcase
         end
         if (book.fill == LIST_DEPTH) growing = 1'b0;
         else if (book.fill == 0) growing = 1'b1;
         else if ($urandom_range(0, 39) == 0) growing = !growing;

         // command mix leans toward filling or draining
         roll = $urandom_range(0, 99);
         if (roll < 3)
            code = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
         else if (roll < 15)
            code = CMD_READ;
         else if (roll < (growing ? 85 : 35))
            code = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
         else
            code = $urandom_range(0, 1) ? CMD_REMOVE_LAST : CMD_REMOVE_AT;

         // mostly positions in or just past the list
         if (book.fill > 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, (book.fill < LIST_DEPTH) ? book.fill
                                                                     : LIST_DEPTH - 1));
         else
            pos = POS_W'($urandom_range(0, 15));

         case ($urandom_range(0, 9))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
         endcase
         push_command(code, pos, word);
      end
   endtask

   initial begin
      reset             = 1'b1;
      send_gap_rate     = 0;
      take_stall_rate   = 0;
      stall_left        = 0;
      cycle_count       = 0;
      req_chan.valid    = 1'b0;
      req_chan.command  = '0;
      req_chan.position = '0;
      req_chan.value    = '0;
      rsp_chan.ready    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      corner_cases();
      random_traffic();
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // drain owed answers, then watch for strays
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.faults == 0)
         $display("PASS positional_list_store");
      else
         $display("FAIL positional_list_store");
      $finish;
   end
endmodule
